>>> rtl/core/bse_pkg.sv
// Package for the byte string escaper: character constants, the escaped-form
// type and the function that builds the escape sequence of one byte.
// No dependencies.
package bse_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned MaxBytes = 4;
  localparam int unsigned IdxW     = $clog2(MaxBytes);

  // Characters that take part in escaping.
  localparam logic [ByteW-1:0] ChBackslash = 8'h5c;
  localparam logic [ByteW-1:0] ChDquote    = 8'h22;
  localparam logic [ByteW-1:0] ChApos      = 8'h27;
  localparam logic [ByteW-1:0] ChCr        = 8'h0d;
  localparam logic [ByteW-1:0] ChLf        = 8'h0a;
  localparam logic [ByteW-1:0] ChTab       = 8'h09;
  localparam logic [ByteW-1:0] ChR         = 8'h72;
  localparam logic [ByteW-1:0] ChN         = 8'h6e;
  localparam logic [ByteW-1:0] ChT         = 8'h74;
  localparam logic [ByteW-1:0] ChX         = 8'h78;
  localparam logic [ByteW-1:0] ChZero      = 8'h30;
  localparam logic [ByteW-1:0] ChLowerA    = 8'h61;
  localparam logic [ByteW-1:0] ChSpace     = 8'h20;
  localparam logic [ByteW-1:0] ChDel       = 8'h7f;

  // Escaped form of one byte: up to four bytes, first in slot zero, and the
  // index of the final byte.
  typedef struct packed {
    logic [MaxBytes-1:0][ByteW-1:0] bytes;
    logic [IdxW-1:0]                last_idx;
  } esc_t;

  // Lowercase hex digit of a nibble.
  function automatic logic [ByteW-1:0] hex_digit(input logic [3:0] nib);
    logic [ByteW-1:0] d;
    if (nib < 4'd10) begin
      d = ChZero + {4'd0, nib};
    end else begin
      d = ChLowerA + {4'd0, nib} - 8'd10;
    end
    return d;
  endfunction

  // Escape sequence of one raw byte.
  function automatic esc_t escape_byte(input logic [ByteW-1:0] ch);
    esc_t e;
    e.bytes    = '0;
    e.last_idx = IdxW'(1);
    e.bytes[0] = ChBackslash;
    unique case (ch)
      ChCr:  e.bytes[1] = ChR;
      ChLf:  e.bytes[1] = ChN;
      ChTab: e.bytes[1] = ChT;
      ChDquote, ChApos, ChBackslash: e.bytes[1] = ch;
      default: begin
        if (ch < ChSpace || ch >= ChDel) begin
          e.bytes[1] = ChX;
          e.bytes[2] = hex_digit(ch[7:4]);
          e.bytes[3] = hex_digit(ch[3:0]);
          e.last_idx = IdxW'(3);
        end else begin
          e.bytes[0] = ch;
          e.last_idx = '0;
        end
      end
    endcase
    return e;
  endfunction

endpackage

>>> rtl/core/bse_in_if.sv
// Input channel of the byte string escaper: valid/ready plus one raw byte.
// Depends on bse_pkg.
interface bse_in_if;
  logic                     valid;
  logic                     ready;
  logic [bse_pkg::ByteW-1:0] in_byte;
  logic                     end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

>>> rtl/core/bse_out_if.sv
// Output channel of the byte string escaper: valid/ready plus one escaped byte.
// Depends on bse_pkg.
interface bse_out_if;
  logic                     valid;
  logic                     ready;
  logic [bse_pkg::ByteW-1:0] out_byte;
  logic                     last_of_run;
  logic                     string_done;

  modport source (output valid, output out_byte, output last_of_run,
                  output string_done, input ready);
  modport sink   (input valid, input out_byte, input last_of_run,
                  input string_done, output ready);
endinterface

>>> rtl/core/byte_string_escaper_core.sv
// Top level of the byte string escaper: stage register with the escaped
// bytes of one input byte, followed by an output register.
// Depends on bse_pkg, bse_in_if and bse_out_if.
//
//  Channel  Dir  Payload                                  Handshake
//  src      in   in_byte[7:0], end_of_string              valid/ready
//  dst      out  out_byte[7:0], last_of_run, string_done  valid/ready
//
// While dst is ready one output byte leaves per cycle. An input byte holds the
// stage until all of its escaped bytes (1, 2 or 4) have moved on, so plain
// printable text then also runs at one byte per cycle. A new byte is taken in the
// cycle its predecessor's final byte moves to the output register. Accepted
// bytes pass the stage, then the output register. Reset is synchronous and
// empties both registers. A stall on dst holds the output register and, once the
// stage is full behind it, drops src ready.
module byte_string_escaper_core (
  input  logic      clk,
  input  logic      rst,
  bse_in_if.sink    src,
  bse_out_if.source dst
);

  // Stage register: escaped bytes of the current transaction.
  logic                                        stg_valid;
  logic [bse_pkg::MaxBytes-1:0][bse_pkg::ByteW-1:0] stg_buf;
  logic [bse_pkg::IdxW-1:0]                    stg_cnt;
  logic [bse_pkg::IdxW-1:0]                    stg_idx;
  logic                                        stg_end;

  // Output register.
  logic                      o_valid;
  logic [bse_pkg::ByteW-1:0] o_byte;
  logic                      o_last;
  logic                      o_done;

  logic          out_move;
  logic          stg_pop;
  logic          stg_final;
  logic          in_take;
  bse_pkg::esc_t esc;

  // Handshake decisions.
  assign out_move  = !o_valid || dst.ready;
  assign stg_pop   = stg_valid && out_move;
  assign stg_final = (stg_idx == stg_cnt);
  assign src.ready = !stg_valid || (stg_pop && stg_final);
  assign in_take   = src.valid && src.ready;
  assign esc       = bse_pkg::escape_byte(src.in_byte);

  // Stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
      stg_idx   <= '0;
    end else if (in_take) begin
      stg_valid <= 1'b1;
      stg_idx   <= '0;
    end else if (stg_pop) begin
      if (stg_final) begin
        stg_valid <= 1'b0;
      end
      stg_idx <= stg_idx + bse_pkg::IdxW'(1);
    end
  end

  // Stage payload, loaded with the escape sequence of each new transaction.
  always_ff @(posedge clk) begin
    if (in_take) begin
      stg_buf <= esc.bytes;
      stg_cnt <= esc.last_idx;
      stg_end <= src.end_of_string;
    end
  end

  // Output register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_move) begin
      o_valid <= stg_valid;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (stg_pop) begin
      o_byte <= stg_buf[stg_idx];
      o_last <= stg_final;
      o_done <= stg_final && stg_end;
    end
  end

  assign dst.valid       = o_valid;
  assign dst.out_byte    = o_byte;
  assign dst.last_of_run = o_last;
  assign dst.string_done = o_done;

  // A string end is only flagged on the last byte of a run.
  a_done_on_last: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> (!o_done || o_last))
    else $error("string_done without last_of_run");

  // The read index never passes the final byte of the sequence.
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    stg_valid |-> (stg_idx <= stg_cnt))
    else $error("stage index beyond escape length");

  // Every multi-byte sequence opens with a backslash.
  a_escape_lead: assert property (@(posedge clk) disable iff (rst)
    (stg_valid && (stg_idx == '0) && (stg_cnt != '0)) |->
      (stg_buf[0] == bse_pkg::ChBackslash))
    else $error("escape sequence without leading backslash");

  // An accepted transaction is held in the stage in the next cycle.
  a_take_fills_stage: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (stg_valid && (stg_idx == '0)))
    else $error("accepted byte not loaded into stage");

  // A finished stage with a free output hands its final byte over.
  a_final_handover: assert property (@(posedge clk) disable iff (rst)
    (stg_pop && stg_final) |=> (o_valid && o_last))
    else $error("final byte of run not presented");

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for byte_string_escaper_core: directed bytes, random strings
// under input gaps and output stalls, then a stretch at full rate.
// Depends on bse_pkg, bse_in_if, bse_out_if and the core itself.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 8;

  // One escaped byte as it should leave the block.
  typedef struct {
    logic [bse_pkg::ByteW-1:0] data;
    logic                      run_last;
    logic                      done;
  } esc_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bse_in_if  in_ch ();
  bse_out_if out_ch ();

  byte_string_escaper_core u_top (
    .clk (clk),
    .rst (rst),
    .src (in_ch),
    .dst (out_ch)
  );

  esc_beat_t   pending_beats[$];
  int unsigned errors      = 0;
  int unsigned chars_sent  = 0;
  int unsigned beats_seen  = 0;
  int unsigned cycle_count = 0;
  bit          idle_on     = 1'b0;

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Lowercase hex digit of one nibble.
  function automatic logic [bse_pkg::ByteW-1:0] nibble_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return 8'h30 + {4'd0, nib};
    end
    return 8'h61 + {4'd0, nib} - 8'd10;
  endfunction

  // Queue up the escaped bytes that one accepted input byte should produce.
  function automatic void predict_escape(input logic [bse_pkg::ByteW-1:0] ch,
                                         input logic eos);
    logic [bse_pkg::ByteW-1:0] seq [4];
    int                        n;
    esc_beat_t                 b;
    seq[0] = bse_pkg::ChBackslash;
    n      = 2;
    if (ch == bse_pkg::ChCr) begin
      seq[1] = bse_pkg::ChR;
    end else if (ch == bse_pkg::ChLf) begin
      seq[1] = bse_pkg::ChN;
    end else if (ch == bse_pkg::ChTab) begin
      seq[1] = bse_pkg::ChT;
    end else if (ch == bse_pkg::ChDquote || ch == bse_pkg::ChApos ||
                 ch == bse_pkg::ChBackslash) begin
      seq[1] = ch;
    end else if (ch < 8'h20 || ch >= 8'h7f) begin
      seq[1] = bse_pkg::ChX;
      seq[2] = nibble_char(ch[7:4]);
      seq[3] = nibble_char(ch[3:0]);
      n      = 4;
    end else begin
      seq[0] = ch;
      n      = 1;
    end
    for (int k = 0; k < n; k++) begin
      b.data     = seq[k];
      b.run_last = (k == n - 1);
      b.done     = (k == n - 1) && eos;
      pending_beats.push_back(b);
    end
  endfunction

  // Present one byte at a falling edge, with an optional gap first, and wait for
  // the transaction to complete.
  task automatic send_char(input logic [bse_pkg::ByteW-1:0] ch, input logic eos);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.in_byte       <= ch;
    in_ch.end_of_string <= eos;
    do @(posedge clk); while (!in_ch.ready);
    predict_escape(ch, eos);
    chars_sent++;
  endtask

  // Drop valid once the input side has nothing more to offer.
  task automatic stop_input();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // Pick a byte, biased toward the named escape characters.
  function automatic logic [bse_pkg::ByteW-1:0] pick_char();
    logic [bse_pkg::ByteW-1:0] specials [6];
    specials = '{bse_pkg::ChCr, bse_pkg::ChLf, bse_pkg::ChTab,
                 bse_pkg::ChDquote, bse_pkg::ChApos, bse_pkg::ChBackslash};
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 8'($urandom_range(8'h20, 8'h7e));
      5, 6:          return specials[$urandom_range(0, 5)];
      7:             return 8'($urandom_range(8'h00, 8'h1f));
      default:       return 8'($urandom_range(8'h7f, 8'hff));
    endcase
  endfunction

  // Send random strings until about the given number of bytes have gone in.
  task automatic send_random_strings(input int unsigned target);
    int unsigned count;
    int unsigned len;
    count = 0;
    while (count < target) begin
      len = $urandom_range(1, 12);
      for (int unsigned i = 0; i < len; i++) begin
        send_char(pick_char(), i == len - 1);
      end
      count += len;
    end
  endtask

  // Extremes of the byte range, every escape class and the class boundaries.
  task automatic test_directed_bytes();
    send_char(8'h00, 1'b0);
    send_char(8'hff, 1'b1);
    send_char(8'h1f, 1'b0);
    send_char(8'h20, 1'b0);
    send_char(8'h7e, 1'b0);
    send_char(8'h7f, 1'b1);
    send_char(8'h80, 1'b0);
    send_char(bse_pkg::ChCr, 1'b0);
    send_char(bse_pkg::ChLf, 1'b1);
    send_char(bse_pkg::ChTab, 1'b0);
    send_char(bse_pkg::ChDquote, 1'b0);
    send_char(bse_pkg::ChApos, 1'b1);
    send_char(bse_pkg::ChBackslash, 1'b0);
    send_char(8'h41, 1'b0);
    send_char(8'h5a, 1'b1);
    send_char(8'h08, 1'b0);
    send_char(8'h0b, 1'b0);
    send_char(8'ha5, 1'b0);
    send_char(8'h5a, 1'b0);
    send_char(8'h3c, 1'b1);
    send_char(8'hc3, 1'b1);
  endtask

  // Random strings with gaps on the input and stalls on the output.
  task automatic test_random_with_idling();
    idle_on = 1'b1;
    send_random_strings(140);
  endtask

  // Random strings at full rate in both directions.
  task automatic test_random_full_rate();
    idle_on = 1'b0;
    send_random_strings(40);
  endtask

  // Output ready: random stalls in bursts while idling is on, always high otherwise.
  initial begin
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Compare every output transaction with the oldest expected byte.
  always @(posedge clk) begin
    esc_beat_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      beats_seen++;
      if (pending_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected output: expected none, actual byte=%h last=%b done=%b",
                 $time, out_ch.out_byte, out_ch.last_of_run, out_ch.string_done);
      end else begin
        want = pending_beats.pop_front();
        if (out_ch.out_byte !== want.data) begin
          errors++;
          $display("%0t: out_byte mismatch: expected %h, actual %h",
                   $time, want.data, out_ch.out_byte);
        end
        if (out_ch.last_of_run !== want.run_last) begin
          errors++;
          $display("%0t: last_of_run mismatch: expected %b, actual %b",
                   $time, want.run_last, out_ch.last_of_run);
        end
        if (out_ch.string_done !== want.done) begin
          errors++;
          $display("%0t: string_done mismatch: expected %b, actual %b",
                   $time, want.done, out_ch.string_done);
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout with %0d bytes still expected", $time, pending_beats.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    in_ch.valid         = 1'b0;
    in_ch.in_byte       = '0;
    in_ch.end_of_string = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_bytes();
    test_random_with_idling();
    test_random_full_rate();
    stop_input();

    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d input bytes and checked %0d escaped output bytes.",
             chars_sent, beats_seen);
    $display("Covered every escape class, gaps and stalls, and a full-rate stretch.");
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
